// File: rtl/core/cds_pkg.sv
// Shared types and constants for the closest direction search block.
`timescale 1ns / 1ps
package cds_pkg;
    localparam int unsigned CompW  = 16;
    localparam int unsigned ScoreW = 32;
    localparam int unsigned IdxW   = 8;
    localparam int unsigned LenW   = 9;
    localparam int unsigned DotW   = 2 * CompW + 2;
    localparam int unsigned NormW  = 2 * CompW + 2;
    localparam int unsigned QW     = 32;

    localparam logic [1:0] RegRefX = 2'd0;
    localparam logic [1:0] RegRefY = 2'd1;
    localparam logic [1:0] RegRefZ = 2'd2;

    typedef struct packed {
        logic signed [CompW-1:0] cand_x;
        logic signed [CompW-1:0] cand_y;
        logic signed [CompW-1:0] cand_z;
        logic                    is_last;
    } t_cand;

    typedef struct packed {
        logic [IdxW-1:0]          best_index;
        logic signed [ScoreW-1:0] best_score;
        logic [LenW-1:0]          list_length;
        logic                     overflow;
    } t_result;

    // Work item handed from front to back.
    typedef struct packed {
        logic                    scored;
        logic                    is_last;
        logic signed [CompW-1:0] cand_x;
        logic signed [CompW-1:0] cand_y;
        logic signed [CompW-1:0] cand_z;
    } t_job;
endpackage

// File: rtl/core/cds_stream_if.sv
// Valid/ready stream interface.
`timescale 1ns / 1ps
interface cds_stream_if #(
    parameter int unsigned WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/closest_direction_search.sv
// A request passes the queue, then the product, sum, bit-serial root and update states
// of the back part; the back part takes a new candidate only once it is done with the last.
// Front part accepts into a two-entry queue while the back part works.
// Reset (synchronous, active low) clears the reference, best score (-1 LSB), index,
// count and overflow flag.
`timescale 1ns / 1ps
module closest_direction_search #(
    parameter int unsigned MAX_CANDIDATES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    cds_stream_if.sink   in_s,
    cds_stream_if.source out_s
);
    logic signed [cds_pkg::CompW-1:0] r_ref_x, r_ref_y, r_ref_z;
    logic          w_push, w_full, w_pop, w_empty;
    cds_pkg::t_job w_jin, w_jout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= '0; r_ref_y <= '0; r_ref_z <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == cds_pkg::RegRefX) r_ref_x <= i_cfg_data;
            if (i_cfg_idx == cds_pkg::RegRefY) r_ref_y <= i_cfg_data;
            if (i_cfg_idx == cds_pkg::RegRefZ) r_ref_z <= i_cfg_data;
        end
    end

    cds_front #(.MAX_CANDIDATES(MAX_CANDIDATES)) u_front (
        .i_clk, .i_rst_n, .in_s, .i_q_full(w_full), .o_push(w_push), .o_job(w_jin));
    cds_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_job(w_jin), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_job(w_jout));
    cds_back u_back (
        .i_clk, .i_rst_n, .i_ref_x(r_ref_x), .i_ref_y(r_ref_y), .i_ref_z(r_ref_z),
        .i_empty(w_empty), .i_job(w_jout), .o_pop(w_pop), .out_s);
endmodule

// File: rtl/core/cds_front.sv
// Front part: takes requests, counts the list, marks overflow candidates.
`timescale 1ns / 1ps
module cds_front #(
    parameter int unsigned MAX_CANDIDATES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cds_stream_if.sink       in_s,
    input  logic             i_q_full,
    output logic             o_push,
    output cds_pkg::t_job    o_job
);
    localparam int unsigned CntW = $clog2(MAX_CANDIDATES + 1);
    logic [CntW-1:0] r_cnt, n_cnt;
    cds_pkg::t_cand  w_c;
    logic            w_room;

    assign w_c        = cds_pkg::t_cand'(in_s.data);
    assign in_s.ready = !i_q_full;
    assign o_push     = in_s.valid && !i_q_full;
    assign w_room     = r_cnt < CntW'(MAX_CANDIDATES);

    always_comb begin
        o_job.scored  = w_room;
        o_job.is_last = w_c.is_last;
        o_job.cand_x  = w_c.cand_x;
        o_job.cand_y  = w_c.cand_y;
        o_job.cand_z  = w_c.cand_z;
        n_cnt = r_cnt;
        if (o_push) begin
            if (w_c.is_last) n_cnt = '0;
            else if (w_room) n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= '0;
        else          r_cnt <= n_cnt;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(MAX_CANDIDATES)) else $error("count past max");
    a_last_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && w_c.is_last |=> r_cnt == '0) else $error("count not cleared");
    a_push_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full) else $error("push into full queue");
endmodule

// File: rtl/core/cds_queue.sv
// Two-entry queue between front and back.
`timescale 1ns / 1ps
module cds_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cds_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output cds_pkg::t_job o_job
);
    cds_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_n;

    assign o_full  = r_n == 2'd2;
    assign o_empty = r_n == 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_n  <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_n <= r_n + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue overrun");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("queue underrun");
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= 2'd2) else $error("queue count");
endmodule

// File: rtl/core/cds_back.sv
// Back part: scores one candidate with a bit-serial quotient search, keeps the best.
`timescale 1ns / 1ps
module cds_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [cds_pkg::CompW-1:0]    i_ref_x,
    input  logic signed [cds_pkg::CompW-1:0]    i_ref_y,
    input  logic signed [cds_pkg::CompW-1:0]    i_ref_z,
    input  logic                                i_empty,
    input  cds_pkg::t_job                       i_job,
    output logic                                o_pop,
    cds_stream_if.source                        out_s
);
    localparam int unsigned DW = cds_pkg::DotW;
    localparam int unsigned NW = cds_pkg::NormW;
    localparam int unsigned QW = cds_pkg::QW;
    localparam int unsigned AW = DW + 16;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_PROD = 5'b00010, S_SUM = 5'b00100,
        S_ITER = 5'b01000, S_DONE = 5'b10000
    } t_state;

    t_state r_st, n_st;
    cds_pkg::t_job r_job;
    logic signed [2*cds_pkg::CompW-1:0] r_px, r_py, r_pz, r_nx, r_ny, r_nz;
    logic [DW-1:0]  r_mag;
    logic           r_neg;
    logic [NW-1:0]  r_n2;
    // Bit-serial search for the largest q <= lim with q*q*n2 <= a*a, i.e. q = floor(a/sqrt(n2)),
    // one bit per cycle from the top, tracking q*q*n2 incrementally.
    logic [2*AW-1:0] r_qqn;      // q*q*n2
    logic [QW+NW-1:0] r_qn;      // q*n2
    logic [QW-1:0]   r_q;
    logic [5:0]      r_bit;
    logic [QW-1:0]   r_lim;
    logic signed [cds_pkg::ScoreW-1:0] r_top;
    logic [cds_pkg::IdxW-1:0] r_pos;
    logic [cds_pkg::LenW-1:0] r_seen;
    logic            r_ovf;
    cds_pkg::t_result r_res;
    logic            r_oval;
    // a*a with a = mag<<16: mag*mag registered in the SUM stage, shifted by 32
    logic [2*DW-1:0] r_mm;

    // candidate step: q' = q + 2^b ; q'^2 n = qqn + 2^(b+1) qn + 2^(2b) n
    logic [2*AW-1:0] w_try;
    logic [2*AW-1:0] w_aa;
    logic [QW-1:0]   w_qt;
    logic signed [DW-1:0] w_dot;
    logic signed [cds_pkg::ScoreW-1:0] w_s;
    logic            w_done_go;

    assign w_qt  = r_q | (QW'(1) << r_bit[4:0]);
    assign w_try = r_qqn + ((2*AW)'(r_qn) << (r_bit[4:0] + 5'd1))
                 + ((2*AW)'(r_n2) << {r_bit[4:0], 1'b0});
    assign w_aa  = (2*AW)'(r_mm) << 32;
    assign w_dot = DW'(r_px) + DW'(r_py) + DW'(r_pz);
    assign w_s   = r_neg ? -$signed(r_q) : $signed(r_q);
    // a result still waiting holds the last candidate of the next list in DONE
    assign w_done_go = !r_job.is_last || !r_oval || out_s.ready;

    assign o_pop       = (r_st == S_IDLE) && !i_empty;
    assign out_s.valid = r_oval;
    assign out_s.data  = r_res;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (!i_empty) n_st = S_PROD;
            S_PROD: n_st = S_SUM;
            S_SUM:  n_st = S_ITER;
            S_ITER: if (r_bit == 6'd0) n_st = S_DONE;
            S_DONE: if (w_done_go) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (r_st == S_PROD) begin
            r_px <= i_ref_x * r_job.cand_x;
            r_py <= i_ref_y * r_job.cand_y;
            r_pz <= i_ref_z * r_job.cand_z;
            r_nx <= r_job.cand_x * r_job.cand_x;
            r_ny <= r_job.cand_y * r_job.cand_y;
            r_nz <= r_job.cand_z * r_job.cand_z;
        end
        if (r_st == S_SUM) begin
            r_neg <= w_dot[DW-1];
            r_mag <= w_dot[DW-1] ? DW'(-w_dot) : DW'(w_dot);
            r_n2  <= NW'($unsigned(r_nx)) + NW'($unsigned(r_ny)) + NW'($unsigned(r_nz));
            r_lim <= w_dot[DW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            r_q   <= '0;
            r_qqn <= '0;
            r_qn  <= '0;
            r_bit <= 6'd31;
        end
        if (r_st == S_ITER) begin
            if (w_qt <= r_lim && w_try <= w_aa) begin
                r_q   <= w_qt;
                r_qqn <= w_try;
                r_qn  <= r_qn + ((QW+NW)'(r_n2) << r_bit[4:0]);
            end
            if (r_bit != 6'd0) r_bit <= r_bit - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_SUM) r_mm <= (w_dot[DW-1] ? DW'(-w_dot) : DW'(w_dot))
                                 * (w_dot[DW-1] ? DW'(-w_dot) : DW'(w_dot));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_top  <= -32'sd1;
            r_pos  <= '0;
            r_seen <= '0;
            r_ovf  <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_DONE && w_done_go) begin
                logic signed [cds_pkg::ScoreW-1:0] v_top;
                logic [cds_pkg::IdxW-1:0]          v_pos;
                logic [cds_pkg::LenW-1:0]          v_seen;
                logic                              v_ovf;
                v_top = r_top; v_pos = r_pos; v_seen = r_seen; v_ovf = r_ovf;
                if (!r_job.scored) v_ovf = 1'b1;
                else begin
                    if (((r_n2 == '0) || (r_mag == '0) ? 32'sd0 : w_s) > v_top) begin
                        v_top = ((r_n2 == '0) || (r_mag == '0)) ? 32'sd0 : w_s;
                        v_pos = r_seen[cds_pkg::IdxW-1:0];
                    end
                    v_seen = r_seen + 1'b1;
                end
                if (r_job.is_last) begin
                    r_res  <= '{best_index: v_pos, best_score: v_top,
                               list_length: v_seen, overflow: v_ovf};
                    r_top  <= -32'sd1;
                    r_pos  <= '0;
                    r_seen <= '0;
                    r_ovf  <= 1'b0;
                end else begin
                    r_top <= v_top; r_pos <= v_pos; r_seen <= v_seen; r_ovf <= v_ovf;
                end
            end
            if (r_st == S_DONE && w_done_go && r_job.is_last) r_oval <= 1'b1;
            else if (r_oval && out_s.ready)                   r_oval <= 1'b0;
        end
    end

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_st == S_PROD) else $error("pop outside idle");
    a_iter_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_ITER && r_bit == 6'd0) |=> r_st == S_DONE) else $error("iter end");
    a_q_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_DONE |-> r_q <= r_lim) else $error("quotient over limit");
endmodule
